>>> src/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle during reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked during reset as well.
`define ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/dpm_pkg.sv
// ----------------------------------------------------------------------------
// dpm_pkg
// Types and constants for the demand-paged memory with predecode marks.
// ----------------------------------------------------------------------------
package dpm_pkg;

    // byte address width of an access
    localparam int ADDR_BITS = 24;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FETCH = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    localparam logic [31:0] ALIGN_MASK = 32'hFFFF_FFFC;

    typedef struct packed {
        cmd_t                 cmd;
        logic [ADDR_BITS-1:0] addr;
        logic [31:0]          write_data;
        logic [3:0]           byte_mask;
    } dpm_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        mark_was_set;
        logic        page_allocated;
        logic        out_of_frames;
    } dpm_out_t;

    // queued access, address already masked and word aligned
    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] addr;
        logic [31:0] write_data;
        logic [3:0]  byte_mask;
    } dpm_work_t;

endpackage

>>> src/demand_paged_memory_with_predecode_marks_core.sv
// ----------------------------------------------------------------------------
// demand_paged_memory_with_predecode_marks_core
// Sparse word memory with on-demand page frames and predecode marks.
// ----------------------------------------------------------------------------
// Input channel s_*: one access word per handshake (write with byte mask,
// read, fetch). A two-entry queue takes words while the back end works.
// Result channel m_*: one result word per access, held until m_ready.
// After leaving the queue an access reads the page table, presents the word
// address, reads the word and updates it for a write or fetch, then offers
// the result; an access accepted on s_* first passes the registered queue.
// An access that claims a new frame first zeroes its 2^(PAGE_OFFSET_BITS-2)
// words, one word a cycle. An unused command goes straight to the result, an
// out-of-frames access right after the page table read. The single back-end
// sequencer, with its registered memory reads, works on one access at a time.
// Reset: aresetn low clears control state; afterward the page table is
// swept to unmapped, all 2^(ADDR_BITS-PAGE_OFFSET_BITS) entries, with s_ready
// high until the queue fills. Frames and marks are cleared when claimed.
// Stall: while m_ready is low the result holds and the back end waits;
// the queue keeps taking words until it is full.
// ----------------------------------------------------------------------------
module demand_paged_memory_with_predecode_marks_core
    import dpm_pkg::*;
#(
    parameter int PAGE_OFFSET_BITS = 12,
    parameter int FRAMES           = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dpm_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output dpm_out_t m_data
);

    logic      q_valid;
    logic      q_pop;
    dpm_work_t q_data;

    dpm_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    dpm_back #(
        .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
        .FRAMES           (FRAMES)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> src/dpm_front.sv
// ----------------------------------------------------------------------------
// dpm_front
// Accepts accesses, aligns and masks the address, queues them two deep.
// ----------------------------------------------------------------------------
module dpm_front
    import dpm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  dpm_in_t   s_data,
    output logic      q_valid,
    output dpm_work_t q_data,
    input  logic      q_pop
);

    localparam logic [31:0] ADDR_MASK =
        (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << ADDR_BITS) - 32'd1);

    dpm_work_t  slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    dpm_work_t  enq;
    logic       push;

    always_comb begin
        enq.cmd        = s_data.cmd;
        enq.addr       = 32'(s_data.addr) & ADDR_MASK & ALIGN_MASK;
        enq.write_data = s_data.write_data;
        enq.byte_mask  = s_data.byte_mask;
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= enq;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop && q_valid) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop && q_valid);
        end
    end

endmodule

>>> src/dpm_back.sv
// ----------------------------------------------------------------------------
// dpm_back
// Page table walk, frame allocation and clearing, word access and result.
// ----------------------------------------------------------------------------
module dpm_back
    import dpm_pkg::*;
#(
    parameter int PAGE_OFFSET_BITS = 12,
    parameter int FRAMES           = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    input  dpm_work_t q_data,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output dpm_out_t  m_data
);

    localparam int PAGE_BITS  = ADDR_BITS - PAGE_OFFSET_BITS;
    localparam int PAGES      = 1 << PAGE_BITS;
    localparam int WOFF_BITS  = PAGE_OFFSET_BITS - 2;
    localparam int WPF        = 1 << WOFF_BITS;
    localparam int FRAME_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FREE_BITS  = $clog2(FRAMES + 1);
    localparam int MEM_BITS   = FRAME_BITS + WOFF_BITS;
    localparam int WORDS      = FRAMES * WPF;

    typedef enum logic [6:0] {
        ST_CLR   = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_PT    = 7'b0000100,
        ST_ZERO  = 7'b0001000,
        ST_WADDR = 7'b0010000,
        ST_RD    = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [PAGE_BITS-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [WOFF_BITS-1:0]  zcnt_reg, zcnt_next;
    logic [FREE_BITS-1:0]  nff_reg, nff_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    dpm_work_t             item_reg, item_next;
    dpm_out_t              res_reg, res_next;
    logic                  alloc_reg, alloc_next;

    // page table: {mapped, frame}
    logic [FRAME_BITS:0]   pt_mem [PAGES];
    logic [FRAME_BITS:0]   pt_rdata_reg;
    logic                  pt_we;
    logic [PAGE_BITS-1:0]  pt_waddr, pt_raddr;
    logic [FRAME_BITS:0]   pt_wdata;

    // frame words: {mark, word}
    logic [32:0]           wm_mem [WORDS];
    logic [32:0]           wm_rdata_reg;
    logic                  wm_we;
    logic [MEM_BITS-1:0]   wm_waddr, wm_raddr;
    logic [32:0]           wm_wdata;

    logic [PAGE_BITS-1:0]  item_page;
    logic [WOFF_BITS-1:0]  item_woff;
    logic [31:0]           lanes;

    assign item_page = item_reg.addr[ADDR_BITS-1:PAGE_OFFSET_BITS];
    assign item_woff = item_reg.addr[PAGE_OFFSET_BITS-1:2];
    assign pt_raddr  = (state_reg == ST_IDLE) ? q_data.addr[ADDR_BITS-1:PAGE_OFFSET_BITS]
                                              : item_page;
    assign wm_raddr  = {frame_reg, item_woff};

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            lanes[8*k +: 8] = {8{item_reg.byte_mask[k]}};
        end
    end

    always_ff @(posedge aclk) begin
        if (pt_we) begin
            pt_mem[pt_waddr] <= pt_wdata;
        end
        pt_rdata_reg <= pt_mem[pt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (wm_we) begin
            wm_mem[wm_waddr] <= wm_wdata;
        end
        wm_rdata_reg <= wm_mem[wm_raddr];
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        zcnt_next    = zcnt_reg;
        nff_next     = nff_reg;
        frame_next   = frame_reg;
        item_next    = item_reg;
        res_next     = res_reg;
        alloc_next   = alloc_reg;
        q_pop        = 1'b0;
        pt_we        = 1'b0;
        pt_waddr     = item_page;
        pt_wdata     = {1'b1, nff_reg[FRAME_BITS-1:0]};
        wm_we        = 1'b0;
        wm_waddr     = {frame_reg, item_woff};
        wm_wdata     = 33'd0;
        case (state_reg)
            ST_CLR: begin
                pt_we        = 1'b1;
                pt_waddr     = clr_cnt_reg;
                pt_wdata     = '0;
                clr_cnt_next = clr_cnt_reg + PAGE_BITS'(1);
                if (&clr_cnt_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    item_next  = q_data;
                    alloc_next = 1'b0;
                    if (q_data.cmd == CMD_NOP) begin
                        res_next   = '0;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_PT;
                    end
                end
            end
            ST_PT: begin
                if (pt_rdata_reg[FRAME_BITS]) begin
                    frame_next = pt_rdata_reg[FRAME_BITS-1:0];
                    state_next = ST_WADDR;
                end else if (nff_reg < FREE_BITS'(FRAMES)) begin
                    // claim the next frame, then clear it
                    pt_we      = 1'b1;
                    frame_next = nff_reg[FRAME_BITS-1:0];
                    nff_next   = nff_reg + FREE_BITS'(1);
                    alloc_next = 1'b1;
                    zcnt_next  = '0;
                    state_next = ST_ZERO;
                end else begin
                    res_next   = '{read_data: 32'd0, mark_was_set: 1'b0,
                                   page_allocated: 1'b0, out_of_frames: 1'b1};
                    state_next = ST_OUT;
                end
            end
            ST_ZERO: begin
                wm_we     = 1'b1;
                wm_waddr  = {frame_reg, zcnt_reg};
                zcnt_next = zcnt_reg + WOFF_BITS'(1);
                if (&zcnt_reg) begin
                    state_next = ST_WADDR;
                end
            end
            ST_WADDR: begin
                state_next = ST_RD;
            end
            ST_RD: begin
                res_next.page_allocated = alloc_reg;
                res_next.out_of_frames  = 1'b0;
                case (item_reg.cmd)
                    CMD_WRITE: begin
                        wm_we    = 1'b1;
                        wm_wdata = {1'b0, (wm_rdata_reg[31:0] & ~lanes)
                                          | (item_reg.write_data & lanes)};
                        res_next.read_data    = 32'd0;
                        res_next.mark_was_set = 1'b0;
                    end
                    CMD_FETCH: begin
                        wm_we    = 1'b1;
                        wm_wdata = {1'b1, wm_rdata_reg[31:0]};
                        res_next.read_data    = wm_rdata_reg[31:0];
                        res_next.mark_was_set = wm_rdata_reg[32];
                    end
                    default: begin
                        res_next.read_data    = wm_rdata_reg[31:0];
                        res_next.mark_was_set = 1'b0;
                    end
                endcase
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            clr_cnt_reg <= '0;
            nff_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            nff_reg     <= nff_next;
        end
    end

    always_ff @(posedge aclk) begin
        zcnt_reg  <= zcnt_next;
        frame_reg <= frame_next;
        item_reg  <= item_next;
        res_reg   <= res_next;
        alloc_reg <= alloc_next;
    end

    assign m_valid = (state_reg == ST_OUT);
    assign m_data  = res_reg;

endmodule

>>> src/dpm_checker.sv
// ----------------------------------------------------------------------------
// dpm_checker
// Port-level checks on the demand-paged memory core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpm_port_checker
    import dpm_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input dpm_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input dpm_out_t m_data
);

    logic stalled_reg;
    logic fault_clean;

    // remember a result word that was offered and not taken
    always_ff @(posedge aclk) begin
        stalled_reg <= aresetn && m_valid && !m_ready;
    end

    assign fault_clean = (m_data.read_data == 32'd0) && !m_data.mark_was_set
                         && !m_data.page_allocated;

    `ASSERT_NEXT(a_no_result_after_reset, aclk, !aresetn, !m_valid)
    `ASSERT_IMPL(a_hold_stalled, aclk, aresetn, stalled_reg, m_valid && $stable(m_data))
    `ASSERT_IMPL(a_fault_is_zero, aclk, aresetn, m_valid && m_data.out_of_frames, fault_clean)
    `ASSERT_IMPL(a_no_result_during_sweep, aclk, aresetn, !$past(aresetn), !m_valid)

endmodule

bind demand_paged_memory_with_predecode_marks_core dpm_port_checker u_dpm_checker (.*);

>>> dv/dpm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpm_checker
// Watches both channels of the paged memory, keeps a model of the page table,
// frame contents and predecode marks, and compares every result word in order.
// ----------------------------------------------------------------------------
module dpm_checker
    import dpm_pkg::*;
#(
    parameter int ADDR_BITS        = 24,
    parameter int PAGE_OFFSET_BITS = 12,
    parameter int FRAMES           = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  dpm_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  dpm_out_t m_data,
    output int       fail_count,
    output int       pending,
    output int       results_seen,
    output int       allocs_seen,
    output int       oof_seen,
    output int       marks_seen
);
    localparam int PAGES = 1 << (ADDR_BITS - PAGE_OFFSET_BITS);
    localparam int WPF   = 1 << (PAGE_OFFSET_BITS - 2);

    bit          page_used  [PAGES];
    int          page_slot  [PAGES];
    logic [31:0] mem_words  [FRAMES * WPF];
    bit          mem_marks  [FRAMES * WPF];
    int          frames_taken;
    dpm_out_t    expected_q [$];

    function automatic dpm_out_t access_memory(dpm_in_t w);
        dpm_out_t    r;
        logic [31:0] a;
        logic [31:0] lanes;
        int          pg;
        int          idx;
        r = '0;
        if (w.cmd == CMD_NOP) return r;
        a  = 32'(w.addr) & ALIGN_MASK;
        pg = int'(a >> PAGE_OFFSET_BITS) & (PAGES - 1);
        if (!page_used[pg]) begin
            if (frames_taken >= FRAMES) begin
                r.out_of_frames = 1'b1;
                return r;
            end
            page_used[pg] = 1;
            page_slot[pg] = frames_taken;
            for (int i = 0; i < WPF; i++) begin
                mem_words[frames_taken * WPF + i] = '0;
                mem_marks[frames_taken * WPF + i] = 0;
            end
            frames_taken++;
            r.page_allocated = 1'b1;
        end
        idx = page_slot[pg] * WPF + (int'(a >> 2) & (WPF - 1));
        case (w.cmd)
            CMD_WRITE: begin
                lanes = '0;
                for (int k = 0; k < 4; k++)
                    if (w.byte_mask[k]) lanes[8*k +: 8] = 8'hFF;
                mem_words[idx] = (mem_words[idx] & ~lanes) | (w.write_data & lanes);
                mem_marks[idx] = 0;
            end
            CMD_READ: r.read_data = mem_words[idx];
            default: begin
                r.read_data    = mem_words[idx];
                r.mark_was_set = mem_marks[idx];
                mem_marks[idx] = 1;
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        dpm_out_t want;
        if (!aresetn) begin
            foreach (page_used[i]) page_used[i] = 0;
            frames_taken = 0;
            expected_q.delete();
            fail_count   <= 0;
            pending      <= 0;
            results_seen <= 0;
            allocs_seen  <= 0;
            oof_seen     <= 0;
            marks_seen   <= 0;
        end else begin
            if (s_valid && s_ready) expected_q.push_back(access_memory(s_data));
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                allocs_seen  <= allocs_seen + m_data.page_allocated;
                oof_seen     <= oof_seen + m_data.out_of_frames;
                marks_seen   <= marks_seen + m_data.mark_was_set;
                if (expected_q.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result word %h", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want !== m_data) begin
                        if (fail_count < 10)
                            $display({"mismatch: exp data=%h mark=%b alloc=%b oof=%b, ",
                                      "got data=%h mark=%b alloc=%b oof=%b"},
                                     want.read_data, want.mark_was_set, want.page_allocated,
                                     want.out_of_frames, m_data.read_data, m_data.mark_was_set,
                                     m_data.page_allocated, m_data.out_of_frames);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_q.size();
        end
    end
endmodule

>>> dv/demand_paged_memory_with_predecode_marks_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// demand_paged_memory_with_predecode_marks_core_test
// Drives directed and random accesses into the paged memory: fresh pages until
// the frames run out, byte-masked writes, read-back and repeated fetches of
// hot words, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module demand_paged_memory_with_predecode_marks_core_test;
    import dpm_pkg::*;

    localparam int WATCHDOG = 200000;

    logic     aclk = 0;
    logic     aresetn = 0;
    logic     s_valid = 0;
    logic     s_ready;
    dpm_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 0;
    dpm_out_t m_data;
    int       fail_count, pending, results_seen, allocs_seen, oof_seen, marks_seen;
    int       words_sent = 0;
    int       quiet_cycles = 0;
    bit       calm = 0;
    bit       hold_off = 0;
    logic [11:0] used_pages [$];

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    demand_paged_memory_with_predecode_marks_core u_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data
    );

    dpm_checker u_chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .fail_count, .pending, .results_seen, .allocs_seen, .oof_seen, .marks_seen
    );

    // receiver: random stall bursts, one long hold-off on request
    always @(posedge aclk) begin
        int n;
        if (!aresetn) m_ready <= 0;
        else if (hold_off) begin
            m_ready <= 0;
            repeat (300) @(posedge aclk);
            hold_off = 0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            m_ready <= 0;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge aclk);
            m_ready <= 1;
        end else m_ready <= 1;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG);
            $display("** demand_paged_memory_with_predecode_marks_core: FAILED **");
            $finish;
        end
    end

    task automatic send_word(cmd_t c, logic [23:0] a, logic [31:0] d, logic [3:0] m);
        int n;
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_valid <= 0;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge aclk);
        end
        s_valid <= 1;
        s_data  <= '{cmd: c, addr: a, write_data: d, byte_mask: m};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    function automatic logic [23:0] hot_addr();
        logic [11:0] pg;
        pg = used_pages[$urandom_range(0, used_pages.size() - 1)];
        // few offsets so fetch marks are revisited
        return {pg, 4'($urandom_range(0, 15)), 6'($urandom_range(0, 3)), 2'($urandom)};
    endfunction

    initial begin
        cmd_t        c;
        logic [23:0] a;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: page extremes, lane masks, marks, nop, low address bits
        send_word(CMD_WRITE, 24'h000003, 32'hFFFF_FFFF, 4'hF);
        send_word(CMD_READ,  24'h000000, '0, 4'h0);
        send_word(CMD_WRITE, 24'h000001, 32'h1234_5678, 4'h5);
        send_word(CMD_READ,  24'h000002, '0, 4'hF);
        send_word(CMD_FETCH, 24'h000000, '0, 4'h0);
        send_word(CMD_FETCH, 24'h000000, '0, 4'h0);
        send_word(CMD_WRITE, 24'h000000, 32'hA5A5_A5A5, 4'h0);
        send_word(CMD_FETCH, 24'h000000, '0, 4'h0);
        send_word(CMD_NOP,   24'hFFFFFF, 32'hFFFF_FFFF, 4'hF);
        send_word(CMD_FETCH, 24'hFFFFFF, '0, 4'h0);
        send_word(CMD_FETCH, 24'hFFFFFC, '0, 4'h0);
        send_word(CMD_WRITE, 24'hFFFFFD, 32'h8000_0001, 4'hA);
        send_word(CMD_READ,  24'hFFFFFE, '0, 4'h0);
        send_word(CMD_READ,  24'h555554, '0, 4'h0);
        send_word(CMD_WRITE, 24'hAAAAA8, 32'h5555_AAAA, 4'hF);
        used_pages = '{12'h000, 12'hFFF, 12'h555, 12'hAAA};

        // long receiver hold-off while offering words
        hold_off = 1;
        for (int i = 0; i < 20; i++) send_word(CMD_READ, hot_addr(), $urandom, 4'hF);
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);

        for (int i = 0; i < 1600; i++) begin
            if (i == 1300) calm = 1;
            c = cmd_t'($urandom_range(0, 2));
            if ($urandom_range(0, 39) == 0) c = CMD_NOP;
            if (used_pages.size() < 16 && $urandom_range(0, 24) == 0) begin
                a = 24'($urandom);
                used_pages.push_back(a[23:12]);
            end else if ($urandom_range(0, 29) == 0) a = 24'($urandom); // maybe out of frames
            else a = hot_addr();
            send_word(c, a, $urandom, 4'($urandom));
            if (i == 700) begin
                s_valid <= 0;
                @(posedge aclk);
                while (pending != 0) @(posedge aclk);
            end
        end
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (2000) @(posedge aclk);

        $display("%0d words sent, %0d results; %0d frame claims, %0d out-of-frame, %0d marked fetches",
                 words_sent, results_seen, allocs_seen, oof_seen, marks_seen);
        if (fail_count == 0 && pending == 0)
            $display("** demand_paged_memory_with_predecode_marks_core: PASSED **");
        else
            $display("** demand_paged_memory_with_predecode_marks_core: FAILED **");
        $finish;
    end
endmodule
